// File: sv/burst_ring_fifo_unit_defines.svh
// Assertion macros shared by the block's modules.
`ifndef BURST_RING_FIFO_UNIT_DEFINES_SVH
`define BURST_RING_FIFO_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define BRF_ASSERT_IMP(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error("implication check failed");
`define BRF_ASSERT_NXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`define BRF_ASSERT_ALW(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("invariant check failed");
`else
`define BRF_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define BRF_ASSERT_NXT(lbl, clk, rstn, pre, post)
`define BRF_ASSERT_ALW(lbl, clk, rstn, cond)
`endif

`endif

// File: sv/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

	localparam int CAP_W = 9;
	localparam int CNT_W = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] MAX_BURST = 7'd64;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DISABLED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_PARTIAL = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENABLED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_RD_ADDR,
		FSM_RD_DATA
	} state_t;

	typedef struct packed {
		logic wr_elem;
		logic rd_start;
		logic rd_discard;
		logic rd_issue;
		logic rd_pop;
		logic clear;
		logic cfg_write;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic rd_none;
		logic rd_final;
	} sts_t;

endpackage

// File: sv/burst_ring_fifo_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// req       req_valid/req_ready    command, burst_count, element_in, first_of_burst,
//                                  last_of_burst, discard
// rsp       rsp_valid/rsp_ready    element_out, has_data, status, moved_count, last,
//                                  fill_level
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A write element, a clear or a discarding read request is taken without leaving the idle state.
// A read request that returns data is accepted in the idle state; each element then
// passes through FSM_RD_ADDR, which issues the registered read of the element store, and
// FSM_RD_DATA, which waits there while rsp_ready is low and the output register is full.
// Reset empties the queue at once; the element store is not cleared.
// A request is taken while a result waits only if rsp_ready frees the output register.

module burst_ring_fifo_unit #(
	parameter int STORE_DEPTH = 256,
	parameter int ELEMENT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    command,
	input  logic [brf_pkg::CNT_W-1:0]     burst_count,
	input  logic [ELEMENT_BITS-1:0]       element_in,
	input  logic                          first_of_burst,
	input  logic                          last_of_burst,
	input  logic                          discard,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [ELEMENT_BITS-1:0]       element_out,
	output logic                          has_data,
	output logic [1:0]                    status,
	output logic [brf_pkg::CNT_W-1:0]     moved_count,
	output logic                          last,
	output logic [brf_pkg::CAP_W-1:0]     fill_level,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [brf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [brf_pkg::CAP_W-1:0]     cfg_data
);

	brf_pkg::ctl_t ctl;
	brf_pkg::sts_t sts;

	brf_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.command      (command),
		.last_of_burst(last_of_burst),
		.discard      (discard),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.sts          (sts),
		.ctl          (ctl)
	);

	brf_datapath #(
		.STORE_DEPTH (STORE_DEPTH),
		.ELEMENT_BITS(ELEMENT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.burst_count   (burst_count),
		.element_in    (element_in),
		.first_of_burst(first_of_burst),
		.last_of_burst (last_of_burst),
		.element_out   (element_out),
		.has_data      (has_data),
		.status        (status),
		.moved_count   (moved_count),
		.last          (last),
		.fill_level    (fill_level)
	);

endmodule

// File: sv/brf_ram.sv
`timescale 1ns / 1ps

module brf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/brf_controller.sv
`timescale 1ns / 1ps
`include "burst_ring_fifo_unit_defines.svh"

module brf_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic [1:0]    command,
	input  logic          last_of_burst,
	input  logic          discard,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  brf_pkg::sts_t sts,
	output brf_pkg::ctl_t ctl
);

	brf_pkg::state_t state_q;
	brf_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;
	logic            req_acc;

	assign out_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == brf_pkg::FSM_IDLE) && out_free && !cfg_valid;
	assign cfg_ready = (state_q == brf_pkg::FSM_IDLE);
	assign req_acc = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			brf_pkg::FSM_IDLE: begin
				if (req_acc && command == brf_pkg::CMD_READ && !sts.rd_none && !discard) begin
					state_d = brf_pkg::FSM_RD_ADDR;
				end
			end
			brf_pkg::FSM_RD_ADDR: begin
				state_d = brf_pkg::FSM_RD_DATA;
			end
			brf_pkg::FSM_RD_DATA: begin
				if (out_free) begin
					state_d = sts.rd_final ? brf_pkg::FSM_IDLE : brf_pkg::FSM_RD_ADDR;
				end
			end
			default: begin
				state_d = brf_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			brf_pkg::FSM_IDLE: begin
				ctl.cfg_write = cfg_valid;
				if (req_acc) begin
					case (command)
						brf_pkg::CMD_WRITE: begin
							ctl.wr_elem = 1'b1;
							ctl.load_out = last_of_burst;
						end
						brf_pkg::CMD_READ: begin
							if (!sts.rd_none) begin
								ctl.rd_discard = discard;
								ctl.rd_start = !discard;
								ctl.load_out = discard;
							end
						end
						brf_pkg::CMD_CLEAR: begin
							ctl.clear = 1'b1;
						end
						default: begin
							ctl.clear = 1'b0;
						end
					endcase
				end
			end
			brf_pkg::FSM_RD_ADDR: begin
				ctl.rd_issue = 1'b1;
			end
			brf_pkg::FSM_RD_DATA: begin
				ctl.rd_pop = out_free;
				ctl.load_out = out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brf_pkg::FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BRF_ASSERT_IMP(a_load_into_free, clk, arst_n, ctl.load_out, out_free)
	`BRF_ASSERT_NXT(a_addr_then_data, clk, arst_n, state_q == brf_pkg::FSM_RD_ADDR, state_q == brf_pkg::FSM_RD_DATA)
	`BRF_ASSERT_ALW(a_no_cfg_and_req, clk, arst_n, !(cfg_valid && cfg_ready && req_acc))
	`BRF_ASSERT_IMP(a_no_req_while_busy, clk, arst_n, state_q != brf_pkg::FSM_IDLE, !req_ready && !ctl.cfg_write)

endmodule

// File: sv/brf_datapath.sv
`timescale 1ns / 1ps
`include "burst_ring_fifo_unit_defines.svh"

module brf_datapath #(
	parameter int STORE_DEPTH = 256,
	parameter int ELEMENT_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  brf_pkg::ctl_t                       ctl,
	output brf_pkg::sts_t                       sts,
	input  logic [brf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [brf_pkg::CAP_W-1:0]           cfg_data,
	input  logic [brf_pkg::CNT_W-1:0]           burst_count,
	input  logic [ELEMENT_BITS-1:0]             element_in,
	input  logic                                first_of_burst,
	input  logic                                last_of_burst,
	output logic [ELEMENT_BITS-1:0]             element_out,
	output logic                                has_data,
	output logic [1:0]                          status,
	output logic [brf_pkg::CNT_W-1:0]           moved_count,
	output logic                                last,
	output logic [brf_pkg::CAP_W-1:0]           fill_level
);

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CMP_W = ((IDX_W > brf_pkg::CAP_W) ? IDX_W : brf_pkg::CAP_W) + 1;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(STORE_DEPTH);

	logic                        enabled_q;
	logic [brf_pkg::CAP_W-1:0]   cap_q;
	logic [IDX_W-1:0]            wr_idx_q;
	logic [IDX_W-1:0]            rd_idx_q;
	logic [brf_pkg::CAP_W-1:0]   held_q;
	logic [brf_pkg::CNT_W-1:0]   allow_q;
	logic [brf_pkg::CNT_W-1:0]   stored_q;
	logic [1:0]                  outcome_q;
	logic [brf_pkg::CNT_W-1:0]   remain_q;
	logic [brf_pkg::CNT_W-1:0]   total_q;

	logic [ELEMENT_BITS-1:0]     element_out_q;
	logic                        has_data_q;
	logic [1:0]                  status_q;
	logic [brf_pkg::CNT_W-1:0]   moved_count_q;
	logic                        last_q;
	logic [brf_pkg::CAP_W-1:0]   fill_level_q;

	logic [CMP_W-1:0]            cap_ext;
	logic [CMP_W-1:0]            effc;
	logic [CMP_W-1:0]            held_ext;
	logic [CMP_W-1:0]            free_space;
	logic [brf_pkg::CNT_W-1:0]   req_sat;
	logic [brf_pkg::CNT_W-1:0]   rd_n;
	logic [brf_pkg::CNT_W-1:0]   allow_c;
	logic [brf_pkg::CNT_W-1:0]   stored_c;
	logic [brf_pkg::CNT_W-1:0]   stored_n;
	logic [1:0]                  outcome_c;
	logic                        store_ok;
	logic [CMP_W-1:0]            wr_nx;
	logic [IDX_W-1:0]            wr_adv;
	logic [CMP_W-1:0]            rd_nx;
	logic [IDX_W-1:0]            rd_adv;
	logic [CMP_W-1:0]            rd_sum;
	logic [IDX_W-1:0]            rd_jump;
	logic [ELEMENT_BITS-1:0]     ram_rdata;

	assign cap_ext = CMP_W'(cap_q);
	assign held_ext = CMP_W'(held_q);

	always_comb begin
		if (cap_q == '0) begin
			effc = CMP_W'(1);
		end else if (cap_ext > DEPTH_C) begin
			effc = DEPTH_C;
		end else begin
			effc = cap_ext;
		end
	end

	assign req_sat = (burst_count > brf_pkg::MAX_BURST) ? brf_pkg::MAX_BURST : burst_count;
	assign rd_n = (brf_pkg::CAP_W'(req_sat) < held_q) ? req_sat : held_q[brf_pkg::CNT_W-1:0];
	assign free_space = (held_ext < effc) ? (effc - held_ext) : '0;

	always_comb begin
		allow_c = allow_q;
		stored_c = stored_q;
		outcome_c = outcome_q;
		if (first_of_burst) begin
			allow_c = '0;
			stored_c = '0;
			if (!enabled_q) begin
				outcome_c = brf_pkg::ST_DISABLED;
			end else if (free_space == '0) begin
				outcome_c = brf_pkg::ST_FULL;
			end else if (CMP_W'(req_sat) <= free_space) begin
				allow_c = req_sat;
				outcome_c = brf_pkg::ST_OK;
			end else begin
				allow_c = free_space[brf_pkg::CNT_W-1:0];
				outcome_c = brf_pkg::ST_PARTIAL;
			end
		end
	end

	assign store_ok = enabled_q && (stored_c < allow_c) && (held_ext < effc);
	assign stored_n = stored_c + brf_pkg::CNT_W'(store_ok);

	assign wr_nx = CMP_W'(wr_idx_q) + CMP_W'(1);
	assign wr_adv = (wr_nx >= effc) ? '0 : wr_nx[IDX_W-1:0];
	assign rd_nx = CMP_W'(rd_idx_q) + CMP_W'(1);
	assign rd_adv = (rd_nx >= effc) ? '0 : rd_nx[IDX_W-1:0];
	assign rd_sum = CMP_W'(rd_idx_q) + CMP_W'(rd_n);
	assign rd_jump = (rd_sum >= effc) ? IDX_W'(rd_sum - effc) : rd_sum[IDX_W-1:0];

	assign sts.rd_none = !enabled_q || (rd_n == '0);
	assign sts.rd_final = (remain_q == brf_pkg::CNT_W'(1));

	brf_ram #(
		.WIDTH(ELEMENT_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ctl.wr_elem && store_ok),
		.wr_addr(wr_idx_q),
		.wr_data(element_in),
		.rd_en  (ctl.rd_issue),
		.rd_addr(rd_idx_q),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			cap_q <= brf_pkg::CAP_RESET;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			held_q <= '0;
			allow_q <= '0;
			stored_q <= '0;
			outcome_q <= brf_pkg::ST_OK;
			remain_q <= '0;
			total_q <= '0;
		end else if (ctl.cfg_write) begin
			if (cfg_index == brf_pkg::REG_QUEUE_ENABLED) begin
				enabled_q <= cfg_data[0];
			end else begin
				cap_q <= cfg_data;
			end
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			held_q <= '0;
			allow_q <= '0;
			stored_q <= '0;
			outcome_q <= brf_pkg::ST_OK;
		end else if (ctl.wr_elem) begin
			if (store_ok) begin
				wr_idx_q <= wr_adv;
				held_q <= held_q + brf_pkg::CAP_W'(1);
			end
			if (last_of_burst) begin
				allow_q <= '0;
				stored_q <= '0;
				outcome_q <= brf_pkg::ST_OK;
			end else begin
				allow_q <= allow_c;
				stored_q <= stored_n;
				outcome_q <= outcome_c;
			end
		end else if (ctl.rd_discard) begin
			rd_idx_q <= rd_jump;
			held_q <= held_q - brf_pkg::CAP_W'(rd_n);
		end else if (ctl.rd_start) begin
			remain_q <= rd_n;
			total_q <= rd_n;
		end else if (ctl.rd_pop) begin
			rd_idx_q <= rd_adv;
			held_q <= held_q - brf_pkg::CAP_W'(1);
			remain_q <= remain_q - brf_pkg::CNT_W'(1);
		end else if (ctl.clear) begin
			rd_idx_q <= wr_idx_q;
			held_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			if (ctl.rd_pop) begin
				element_out_q <= ram_rdata;
				has_data_q <= 1'b1;
				status_q <= brf_pkg::ST_OK;
				moved_count_q <= sts.rd_final ? total_q : '0;
				last_q <= sts.rd_final;
				fill_level_q <= held_q - brf_pkg::CAP_W'(1);
			end else if (ctl.rd_discard) begin
				element_out_q <= '0;
				has_data_q <= 1'b0;
				status_q <= brf_pkg::ST_OK;
				moved_count_q <= rd_n;
				last_q <= 1'b1;
				fill_level_q <= held_q - brf_pkg::CAP_W'(rd_n);
			end else begin
				element_out_q <= '0;
				has_data_q <= 1'b0;
				status_q <= enabled_q ? outcome_c : brf_pkg::ST_DISABLED;
				moved_count_q <= stored_n;
				last_q <= 1'b1;
				fill_level_q <= held_q + brf_pkg::CAP_W'(store_ok);
			end
		end
	end

	assign element_out = element_out_q;
	assign has_data = has_data_q;
	assign status = status_q;
	assign moved_count = moved_count_q;
	assign last = last_q;
	assign fill_level = fill_level_q;

	`BRF_ASSERT_ALW(a_held_within_cap, clk, arst_n, held_ext <= effc)
	`BRF_ASSERT_ALW(a_index_within_cap, clk, arst_n, (CMP_W'(wr_idx_q) < effc) && (CMP_W'(rd_idx_q) < effc))
	`BRF_ASSERT_IMP(a_pop_not_empty, clk, arst_n, ctl.rd_pop || ctl.rd_issue, held_q != '0 && remain_q != '0)

endmodule
